[hdl/tsfr_pkg.sv]
// ============================================================================
// tsfr_pkg: shared types and constants of the typed structure frame receiver
// Holds the field widths, status and register codes, the controller state
// type, the command and status groups between controller and datapath, and
// the size-code helper functions.
// ============================================================================
package tsfr_pkg;

    // Field widths of the channels and registers
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned FBYTES_W   = 9;
    localparam int unsigned UPD_W      = 6;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned VCOUNT_W   = 6;
    localparam int unsigned CODES_W    = 64;
    localparam int unsigned VAR_W      = 64;
    localparam int unsigned CODE_IDX_W = 5;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 6;

    // Frame layout: three ID bytes, two index bytes, variables, one checksum
    localparam int unsigned HDR_BYTES      = 5;
    localparam int unsigned OVERHEAD_BYTES = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [BYTE_W-1:0]  BYTE_MASK = 8'hFF;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_HDR_SHORT = 3'd1,
        ST_ID_BAD    = 3'd2,
        ST_IDX_BAD   = 3'd3,
        ST_SHORT     = 3'd4,
        ST_CKS_BAD   = 3'd5
    } status_code_t;

    // Configuration register indexes (byte address is eight times the index)
    typedef enum logic [2:0] {
        REG_DEVICE_ID   = 3'd0,
        REG_TYPE_ID     = 3'd1,
        REG_INSTANCE_ID = 3'd2,
        REG_VAR_COUNT   = 3'd3,
        REG_SIZE_CODES  = 3'd4
    } reg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        S_RECV,
        S_CHECK,
        S_SIZE,
        S_LENCHK,
        S_SUM,
        S_VERIFY,
        S_LOAD,
        S_RESULT
    } fsm_state_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [BYTE_W-1:0]   device_id;
        logic [BYTE_W-1:0]   type_id;
        logic [BYTE_W-1:0]   instance_id;
        logic [VCOUNT_W-1:0] var_count;
        logic [CODES_W-1:0]  size_codes;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic         rx_en;
        logic         check_start;
        logic         size_step;
        logic         sum_start;
        logic         acc_sum;
        logic         load_start;
        logic         acc_load;
        logic         set_code;
        status_code_t code;
        logic         res_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_acc;
        logic hdr_short;
        logic id_bad;
        logic idx_bad;
        logic size_done;
        logic len_short;
        logic rd_done;
        logic cks_ok;
        logic out_free;
    } dp_stat_t;

    // Size code of variable idx
    function automatic logic [1:0] code_of(input logic [CODES_W-1:0] codes,
                                           input logic [CODE_IDX_W-1:0] idx);
        code_of = codes[{idx, 1'b0} +: 2];
    endfunction

    // Byte count of a size code
    function automatic logic [3:0] size_bytes(input logic [1:0] code);
        case (code)
            2'd0:    size_bytes = 4'd1;
            2'd1:    size_bytes = 4'd2;
            2'd2:    size_bytes = 4'd4;
            default: size_bytes = 4'd8;
        endcase
    endfunction

    // Index of the last byte lane of a size code
    function automatic logic [2:0] last_lane(input logic [1:0] code);
        case (code)
            2'd0:    last_lane = 3'd0;
            2'd1:    last_lane = 3'd1;
            2'd2:    last_lane = 3'd3;
            default: last_lane = 3'd7;
        endcase
    endfunction

endpackage

[hdl/tsfr_if.sv]
// ============================================================================
// tsfr_if: streaming channel interfaces of the frame receiver
// A byte channel carrying frame bytes and a result channel carrying one
// status item per frame, both with a valid/ready handshake.
// ============================================================================
interface tsfr_byte_if;
    import tsfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface tsfr_result_if;
    import tsfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FBYTES_W-1:0] frame_bytes;
    logic [UPD_W-1:0]    updated_index;

    modport source (output valid, output status, output frame_bytes,
                    output updated_index, input ready);
    modport sink   (input valid, input status, input frame_bytes,
                    input updated_index, output ready);
endinterface

[hdl/tsfr_regs.sv]
// ============================================================================
// tsfr_regs: configuration register file
// APB-style write and read access to the ID bytes, the variable count and
// the packed variable size codes. Registers sit on 8-byte boundaries.
// ============================================================================
module tsfr_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsfr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tsfr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tsfr_pkg::APB_DATA_W-1:0]   prdata,
    output tsfr_pkg::cfg_t                    cfg
);
    import tsfr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes complete in the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEVICE_ID:   cfg_reg.device_id   <= pwdata[BYTE_W-1:0];
                REG_TYPE_ID:     cfg_reg.type_id     <= pwdata[BYTE_W-1:0];
                REG_INSTANCE_ID: cfg_reg.instance_id <= pwdata[BYTE_W-1:0];
                REG_VAR_COUNT:   cfg_reg.var_count   <= pwdata[VCOUNT_W-1:0];
                REG_SIZE_CODES:  cfg_reg.size_codes  <= pwdata[CODES_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read data, zero-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            REG_DEVICE_ID:   prdata = APB_DATA_W'(cfg_reg.device_id);
            REG_TYPE_ID:     prdata = APB_DATA_W'(cfg_reg.type_id);
            REG_INSTANCE_ID: prdata = APB_DATA_W'(cfg_reg.instance_id);
            REG_VAR_COUNT:   prdata = APB_DATA_W'(cfg_reg.var_count);
            REG_SIZE_CODES:  prdata = APB_DATA_W'(cfg_reg.size_codes);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tsfr_ctrl.sv]
// ============================================================================
// tsfr_ctrl: frame receiver controller
// Sequences reception, the header checks, the size walk, the length check,
// the checksum pass, the variable load pass and the result hand-off.
// ============================================================================
module tsfr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsfr_pkg::dp_stat_t stat,
    output tsfr_pkg::dp_cmd_t  cmd
);
    import tsfr_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;

        unique case (state_reg)
            S_RECV:
            begin
                cmd.rx_en = 1'b1;
                if (stat.last_acc)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                cmd.check_start = 1'b1;
                if (stat.hdr_short)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_HDR_SHORT;
                    state_next   = S_RESULT;
                end
                else if (stat.id_bad)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_ID_BAD;
                    state_next   = S_RESULT;
                end
                else if (stat.idx_bad)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_IDX_BAD;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_SIZE;
                end
            end

            S_SIZE:
            begin
                if (stat.size_done)
                begin
                    state_next = S_LENCHK;
                end
                else
                begin
                    cmd.size_step = 1'b1;
                end
            end

            S_LENCHK:
            begin
                if (stat.len_short)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_SHORT;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = S_SUM;
                end
            end

            S_SUM:
            begin
                cmd.acc_sum = 1'b1;
                if (stat.rd_done)
                begin
                    state_next = S_VERIFY;
                end
            end

            S_VERIFY:
            begin
                cmd.set_code = 1'b1;
                if (stat.cks_ok)
                begin
                    cmd.code       = ST_OK;
                    cmd.load_start = 1'b1;
                    state_next     = S_LOAD;
                end
                else
                begin
                    cmd.code   = ST_CKS_BAD;
                    state_next = S_RESULT;
                end
            end

            S_LOAD:
            begin
                cmd.acc_load = 1'b1;
                if (stat.rd_done)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_RECV;
                end
            end

            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

endmodule

[hdl/tsfr_dp.sv]
// ============================================================================
// tsfr_dp: frame receiver datapath
// Frame buffer memory, byte counter, header capture, total length walk,
// a sequential memory reader shared by the checksum and load passes, the
// variable store and the result output register.
// ============================================================================
module tsfr_dp
#(
    parameter int unsigned MAX_VARS    = 32,
    parameter int unsigned FRAME_DEPTH = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsfr_pkg::cfg_t       cfg,
    input  tsfr_pkg::dp_cmd_t    cmd,
    output tsfr_pkg::dp_stat_t   stat,
    tsfr_byte_if.sink            rx_chan,
    tsfr_result_if.source        status_chan
);
    import tsfr_pkg::*;

    localparam int unsigned FA_W = $clog2(FRAME_DEPTH);
    localparam int unsigned VC_W = $clog2(MAX_VARS + 1);
    localparam int unsigned VI_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

    // Frame buffer and variable store
    logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];
    logic [VAR_W-1:0]  var_store_reg [MAX_VARS];

    // Reception
    logic [COUNT_W-1:0] count_reg;
    logic [BYTE_W-1:0]  hdr_reg [HDR_BYTES];
    logic               rx_acc;

    // Length walk
    logic [FBYTES_W-1:0] total_reg;
    logic [VC_W-1:0]     vi_reg;

    // Memory reader
    logic [FBYTES_W-1:0] ptr_reg;
    logic [FBYTES_W-1:0] end_reg;
    logic [FBYTES_W-1:0] ret_idx_reg;
    logic                ret_valid_reg;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                issuing;

    // Checksum and load accumulation
    logic [BYTE_W-1:0] sum_reg;
    logic              cks_ok_reg;
    logic [2:0]        lane_reg;
    logic [VAR_W-1:0]  value_reg;
    logic [VAR_W-1:0]  value_next;
    logic [1:0]        cur_code;

    // Result
    status_code_t        code_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FBYTES_W-1:0] frame_bytes_reg;
    logic [UPD_W-1:0]    upd_reg;

    // Decoded header fields
    logic [COUNT_W-1:0]  idx;
    logic [VCOUNT_W-1:0] n_eff;
    logic                idx_zero;

    assign rx_acc   = cmd.rx_en && rx_chan.valid;
    assign idx      = {hdr_reg[4], hdr_reg[3]};
    assign idx_zero = (idx == '0);
    assign n_eff    = (cfg.var_count > VCOUNT_W'(MAX_VARS)) ? VCOUNT_W'(MAX_VARS)
                                                            : cfg.var_count;
    assign issuing  = (ptr_reg < end_reg);
    assign cur_code = code_of(cfg.size_codes, CODE_IDX_W'(vi_reg));

    // Status towards the controller
    always_comb
    begin
        stat.last_acc  = rx_acc && rx_chan.frame_end;
        stat.hdr_short = (count_reg < COUNT_W'(HDR_BYTES));
        stat.id_bad    = (hdr_reg[0] != cfg.device_id) ||
                         (hdr_reg[1] != cfg.type_id) ||
                         (hdr_reg[2] != cfg.instance_id);
        stat.idx_bad   = !idx_zero && ((idx - COUNT_W'(1)) >= COUNT_W'(n_eff));
        stat.size_done = !idx_zero || (VCOUNT_W'(vi_reg) == n_eff);
        stat.len_short = (count_reg < COUNT_W'(total_reg));
        stat.rd_done   = !issuing && !ret_valid_reg;
        stat.cks_ok    = cks_ok_reg;
        stat.out_free  = !out_valid_reg || status_chan.ready;
    end

    // Current variable with the returned byte placed in its lane
    always_comb
    begin
        value_next = value_reg;
        value_next[{lane_reg, 3'b000} +: BYTE_W] = rd_data_reg;
    end

    // Frame buffer: write during reception, registered read for the passes
    always_ff @(posedge clk)
    begin
        if (rx_acc && (count_reg < COUNT_W'(FRAME_DEPTH)))
        begin
            frame_mem[count_reg[FA_W-1:0]] <= rx_chan.rx_byte;
        end
        rd_data_reg <= frame_mem[FA_W'(ptr_reg)];
    end

    // Control registers: byte counter, reader pointers, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            end_reg       <= '0;
            ret_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Byte counter saturates and clears once the result is issued
            if (cmd.res_load)
            begin
                count_reg <= '0;
            end
            else if (rx_acc && (count_reg != COUNT_MAX))
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end

            // Reader range: whole frame for the checksum, variable bytes for load
            if (cmd.sum_start)
            begin
                ptr_reg <= '0;
                end_reg <= total_reg;
            end
            else if (cmd.load_start)
            begin
                ptr_reg <= FBYTES_W'(HDR_BYTES);
                end_reg <= total_reg - FBYTES_W'(1);
            end
            else if (issuing)
            begin
                ptr_reg <= ptr_reg + FBYTES_W'(1);
            end
            ret_valid_reg <= issuing;

            // Output register holds until the result transfer completes
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Variable store, cleared at reset, written one variable per completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VARS; i++)
            begin
                var_store_reg[i] <= '0;
            end
        end
        else if (cmd.acc_load && ret_valid_reg && (lane_reg == last_lane(cur_code)))
        begin
            var_store_reg[vi_reg[VI_W-1:0]] <= value_next;
        end
    end

    // Datapath registers without reset
    always_ff @(posedge clk)
    begin
        // Header capture while the first bytes arrive
        if (rx_acc && (count_reg < COUNT_W'(HDR_BYTES)))
        begin
            hdr_reg[count_reg[2:0]] <= rx_chan.rx_byte;
        end

        // Total length: overhead plus the selected variable sizes
        if (cmd.check_start)
        begin
            total_reg <= FBYTES_W'(OVERHEAD_BYTES) + (idx_zero ? FBYTES_W'(0) :
                         FBYTES_W'(size_bytes(code_of(cfg.size_codes,
                                                      CODE_IDX_W'(idx - COUNT_W'(1))))));
            vi_reg    <= '0;
        end
        else if (cmd.size_step)
        begin
            total_reg <= total_reg + FBYTES_W'(size_bytes(cur_code));
            vi_reg    <= vi_reg + VC_W'(1);
        end
        else if (cmd.load_start)
        begin
            vi_reg <= idx_zero ? VC_W'(0) : VC_W'(idx - COUNT_W'(1));
        end
        else if (cmd.acc_load && ret_valid_reg && (lane_reg == last_lane(cur_code)))
        begin
            vi_reg <= vi_reg + VC_W'(1);
        end

        // Checksum pass: add all bytes but the last, compare the last
        if (cmd.sum_start)
        begin
            sum_reg    <= '0;
            cks_ok_reg <= 1'b0;
        end
        else if (cmd.acc_sum && ret_valid_reg)
        begin
            if (ret_idx_reg == end_reg - FBYTES_W'(1))
            begin
                cks_ok_reg <= (sum_reg == rd_data_reg);
            end
            else
            begin
                sum_reg <= (sum_reg + rd_data_reg) & BYTE_MASK;
            end
        end
        ret_idx_reg <= ptr_reg;

        // Load pass: gather little-endian bytes of each variable
        if (cmd.load_start)
        begin
            lane_reg  <= '0;
            value_reg <= '0;
        end
        else if (cmd.acc_load && ret_valid_reg)
        begin
            if (lane_reg == last_lane(cur_code))
            begin
                lane_reg  <= '0;
                value_reg <= '0;
            end
            else
            begin
                lane_reg  <= lane_reg + 3'd1;
                value_reg <= value_next;
            end
        end

        // Result code and output payload
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.res_load)
        begin
            status_reg      <= code_reg;
            frame_bytes_reg <= (code_reg == ST_OK) ? total_reg : '0;
            upd_reg         <= (code_reg == ST_OK) ? UPD_W'(idx) : '0;
        end
    end

    // Channel outputs
    assign rx_chan.ready             = cmd.rx_en;
    assign status_chan.valid         = out_valid_reg;
    assign status_chan.status        = status_reg;
    assign status_chan.frame_bytes   = frame_bytes_reg;
    assign status_chan.updated_index = upd_reg;

endmodule

[hdl/typed_struct_frame_receiver_core.sv]
// ============================================================================
// typed_struct_frame_receiver_core: typed structure frame receiver
// Buffers a received frame, checks its ID, index, length and checksum, and
// on success writes the selected variables into the variable store.
// ============================================================================
// Usage:
// Frame bytes arrive on rx_chan, one transfer per byte, with frame_end set
// on the last byte. While a frame is being received a byte is taken every
// cycle. After the last byte the block stops taking bytes and works through
// the buffered frame: a header check, a walk over the variables to add up
// the frame length when all variables are selected, a length check, a
// checksum pass reading the frame buffer one byte per cycle, and a load
// pass reading the variable bytes one per cycle through the same read port.
// A failed frame stops at the check that fails and so finishes sooner.
// One status transfer per frame then leaves on status_chan. The result
// waits in an output register, so reception of the next frame resumes while
// it waits; a second result waits for the first to be taken.
// Reset clears the configuration, the byte counter and the variable store;
// the frame buffer needs no clearing. The user writes the configuration through
// the APB port only while no frame is in progress; the block does not enforce it.
// ============================================================================
module typed_struct_frame_receiver_core
#(
    parameter int unsigned MAX_VARS    = 32,
    parameter int unsigned FRAME_DEPTH = 512
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tsfr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tsfr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    tsfr_byte_if.sink                       rx_chan,
    tsfr_result_if.source                   status_chan
);
    import tsfr_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Every transfer completes without wait states
    assign pready = 1'b1;

    // Configuration registers
    tsfr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Controller
    tsfr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath
    tsfr_dp
    #(
        .MAX_VARS    (MAX_VARS),
        .FRAME_DEPTH (FRAME_DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .rx_chan     (rx_chan),
        .status_chan (status_chan)
    );

endmodule
